>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property that must also hold during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/csw_pkg.sv
// Types, constants and decode helpers of the compressed stream length walker.
package csw_pkg;

    localparam int unsigned COUNT_BITS = 20;
    localparam int unsigned LEN_W      = 20;
    localparam int unsigned SKIP_W     = 11;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [DATA_W-1:0]     END_CODE  = 8'hFF;

    localparam logic [2:0] CMD_COPY      = 3'd0;
    localparam logic [2:0] CMD_SINGLE_A  = 3'd1;
    localparam logic [2:0] CMD_SINGLE_B  = 3'd3;
    localparam logic [2:0] CMD_EXT_ALIAS = 3'd4;
    localparam logic [2:0] CMD_EXT       = 3'd7;

    typedef enum logic [2:0] {
        PH_CTRL = 3'b001,
        PH_EXT  = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [2:0]              pending_command;
        logic [1:0]              high_length_bits;
        logic [SKIP_W-1:0]       skip_remaining;
        logic [COUNT_BITS-1:0]   byte_count;
    } walk_state_t;

    typedef struct packed {
        logic [LEN_W-1:0] stream_length;
        logic             ok;
    } walk_result_t;

    localparam walk_state_t STATE_RESET = '{
        phase:            PH_CTRL,
        pending_command:  3'd0,
        high_length_bits: 2'd0,
        skip_remaining:   '0,
        byte_count:       '0
    };

    // Number of payload bytes that follow a header.
    function automatic logic [SKIP_W-1:0] payload_size(input logic [2:0] cmd,
                                                       input logic [SKIP_W-1:0] len);
        logic [SKIP_W-1:0] size;
        case (cmd) inside
            CMD_COPY:                   size = len;
            CMD_SINGLE_A, CMD_SINGLE_B: size = SKIP_W'(1);
            default:                    size = SKIP_W'(2);
        endcase
        return size;
    endfunction

endpackage

>>> hw/rtl/csw_step.sv
// Header decode and state update for one byte of the compressed stream.
module csw_step (
    input  csw_pkg::walk_state_t             st,
    input  logic [csw_pkg::DATA_W-1:0]       data_byte,
    input  logic                             last_byte,
    output csw_pkg::walk_state_t             st_next,
    output logic                             res_valid,
    output csw_pkg::walk_result_t            res
);
    import csw_pkg::*;

    logic [COUNT_BITS-1:0] count_inc;
    logic [2:0]            ext_cmd;
    logic [SKIP_W-1:0]     ext_len;
    logic [SKIP_W-1:0]     short_len;
    logic [SKIP_W-1:0]     skip_dec;
    logic                  terminate;

    assign count_inc = (st.byte_count == COUNT_MAX) ? st.byte_count
                                                    : st.byte_count + COUNT_BITS'(1);
    assign ext_cmd   = (st.pending_command == CMD_EXT) ? CMD_EXT_ALIAS : st.pending_command;
    assign ext_len   = {1'b0, st.high_length_bits, data_byte} + SKIP_W'(1);
    assign short_len = SKIP_W'(data_byte[4:0]) + SKIP_W'(1);
    assign skip_dec  = (st.skip_remaining != '0) ? st.skip_remaining - SKIP_W'(1)
                                                 : st.skip_remaining;

    always_comb begin
        st_next            = st;
        st_next.byte_count = count_inc;
        terminate          = 1'b0;
        res.stream_length  = LEN_W'(count_inc);
        res.ok             = 1'b0;

        case (st.phase)
            PH_EXT: begin
                st_next.skip_remaining = payload_size(ext_cmd, ext_len);
                st_next.phase          = PH_SKIP;
            end
            PH_SKIP: begin
                st_next.skip_remaining = skip_dec;
                if (skip_dec == '0) begin
                    st_next.phase = PH_CTRL;
                end
            end
            default: begin
                if (data_byte == END_CODE) begin
                    terminate = 1'b1;
                    res.ok    = 1'b1;
                end else if (data_byte[7:5] == CMD_EXT) begin
                    st_next.high_length_bits = data_byte[1:0];
                    st_next.pending_command  = data_byte[4:2];
                    st_next.phase            = PH_EXT;
                end else begin
                    st_next.skip_remaining = payload_size(data_byte[7:5], short_len);
                    st_next.phase          = PH_SKIP;
                end
            end
        endcase

        // A stream that runs out of data reports what was counted so far.
        res_valid = terminate || last_byte;
        if (res_valid) begin
            st_next = STATE_RESET;
        end
    end

endmodule

>>> hw/rtl/compressed_stream_length_walker.sv
// A result is registered; it appears on the master side in the cycle after its byte.
// Throughput: one byte per cycle while the output is not stalled; the state update is
// a single decode between registers. A result waiting in the output register stops
// input only while it is not being taken. Reset (aresetn low at a rising edge) returns
// the walker to expect a control byte with a zero count and empties the output register.
module compressed_stream_length_walker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csw_pkg::DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csw_pkg::M_TDATA_W-1:0] m_tdata,   // [19:0] stream_length, [23:20] zero
    output logic                          m_tuser    // ok
);
    import csw_pkg::*;

    walk_state_t  state_reg;
    walk_state_t  state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    walk_result_t result_reg;
    walk_result_t step_res;
    logic         step_valid;
    logic         accept;

    csw_step u_step (
        .st        (state_reg),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .st_next   (state_next),
        .res_valid (step_valid),
        .res       (step_res)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (accept) begin
            out_valid_next = step_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step_valid) begin
            result_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg.stream_length);
    assign m_tuser  = result_reg.ok;

endmodule

>>> hw/rtl/csw_checker.sv
// Port-level checks of the compressed stream length walker, bound to the top level.
`include "assert_macros.svh"

module csw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [csw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import csw_pkg::*;

    // A stalled result keeps its value.
    `ASSERT_CLK(a_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // The final byte of the data always produces a result in the next cycle.
    `ASSERT_CLK(a_last_gives_result, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> m_tvalid, "no result after last byte")

    // An empty output register never blocks the input.
    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")

    // Every result counts at least the byte that caused it, and the padding is zero.
    `ASSERT_CLK(a_length_sane, aclk, aresetn, m_tvalid |-> m_tdata[LEN_W-1:0] != '0 && m_tdata[M_TDATA_W-1:LEN_W] == '0, "bad stream length")

    // Reset empties the output register.
    `ASSERT_CLK_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result present after reset")

endmodule

bind compressed_stream_length_walker csw_checker u_csw_checker (.*);
